// ----- hw/rtl/sample_frame_deframer_defines.svh -----
// ---------------------------------------------------------------------------
// Sample frame deframer assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ---------------------------------------------------------------------------
`ifndef SAMPLE_FRAME_DEFRAMER_DEFINES_SVH
`define SAMPLE_FRAME_DEFRAMER_DEFINES_SVH

// Condition that holds at every edge outside reset.
`define SFD_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define SFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/sfd_pkg.sv -----
// ---------------------------------------------------------------------------
// Sample frame deframer package
// Sizes, status codes and register indexes shared by the deframer.
// ---------------------------------------------------------------------------
package sfd_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int IDX_W       = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int CFG_IDX_W   = 8;

  localparam logic [7:0] START_MARKER_RST = 8'hAA;
  localparam logic [7:0] END_MARKER_RST   = 8'hEF;

  localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_SAMPLE   = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BAD_END  = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

  typedef enum logic [5:0] {
    PH_HUNT  = 6'b000001,
    PH_LEN   = 6'b000010,
    PH_HIGH  = 6'b000100,
    PH_LOW   = 6'b001000,
    PH_END   = 6'b010000,
    PH_DRAIN = 6'b100000
  } phase_t;

endpackage

// ----- hw/rtl/sample_frame_deframer.sv -----
// ---------------------------------------------------------------------------
// Sample frame deframer
// Parses start marker, length, big-endian samples and end marker; releases
// the buffered samples of a good frame from a single-port sample memory.
// ---------------------------------------------------------------------------
// One received byte is taken per cycle while the block parses, as long as
// no readback read is pending and the output register is free or being
// emptied. A frame with an oversized length, a bad end byte or zero length
// gives a single status request on the byte that decides it. A good frame
// of N samples is then read back through the memory's single read port, one
// read per cycle while the output side takes requests, and input waits until
// the last read is in the output register. The sample memory needs no
// clearing pass: only entries written in the current frame are read.
`include "sample_frame_deframer_defines.svh"

module sample_frame_deframer
  import sfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [15:0]          out_sample_value,
  output logic [1:0]           out_frame_status,
  output logic                 out_last_of_frame,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   frame_len_r, frame_len_nxt;
  logic [CNT_W-1:0]   seen_r, seen_nxt;
  logic [CNT_W-1:0]   seen_inc;
  logic [7:0]         high_byte_r, high_byte_nxt;
  logic [CNT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]   rd_idx_inc;
  logic [7:0]         start_marker_r;
  logic [7:0]         end_marker_r;

  logic [15:0]        sample_mem_r [MAX_SAMPLES];
  logic [15:0]        rd_data_r;
  logic               rd_pend_r;
  logic               rd_last_r;

  logic               out_valid_r;
  logic [15:0]        out_value_r;
  status_t            out_status_r;
  logic               out_last_r;

  logic               in_acc;
  logic               load_ram;
  logic               rd_issue;
  logic               wr_en;
  logic               st_load;
  status_t            st_code;
  logic               out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign load_ram  = rd_pend_r && out_free;
  assign rd_issue  = (phase_r == PH_DRAIN) && (!rd_pend_r || load_ram);
  assign in_ready  = (phase_r != PH_DRAIN) && !rd_pend_r && out_free;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign seen_inc   = CNT_W'(seen_r + 1'b1);
  assign rd_idx_inc = CNT_W'(rd_idx_r + 1'b1);

  always_comb begin
    phase_nxt     = phase_r;
    frame_len_nxt = frame_len_r;
    seen_nxt      = seen_r;
    high_byte_nxt = high_byte_r;
    rd_idx_nxt    = rd_idx_r;
    wr_en         = 1'b0;
    st_load       = 1'b0;
    st_code       = ST_SAMPLE;
    if (in_acc) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (in_rx_byte == start_marker_r) begin
            frame_len_nxt = '0;
            seen_nxt      = '0;
            phase_nxt     = PH_LEN;
          end
        end
        PH_LEN: begin
          seen_nxt = '0;
          if (in_rx_byte > 8'(MAX_SAMPLES)) begin
            st_load       = 1'b1;
            st_code       = ST_TOO_LONG;
            frame_len_nxt = '0;
            phase_nxt     = PH_HUNT;
          end else begin
            frame_len_nxt = in_rx_byte[CNT_W-1:0];
            phase_nxt     = (in_rx_byte == 8'd0) ? PH_END : PH_HIGH;
          end
        end
        PH_HIGH: begin
          high_byte_nxt = in_rx_byte;
          phase_nxt     = PH_LOW;
        end
        PH_LOW: begin
          wr_en     = (seen_r < CNT_W'(MAX_SAMPLES));
          seen_nxt  = seen_inc;
          phase_nxt = (seen_inc >= frame_len_r) ? PH_END : PH_HIGH;
        end
        PH_END: begin
          seen_nxt = '0;
          if (in_rx_byte != end_marker_r) begin
            st_load       = 1'b1;
            st_code       = ST_BAD_END;
            frame_len_nxt = '0;
            phase_nxt     = PH_HUNT;
          end else if (frame_len_r == '0) begin
            st_load   = 1'b1;
            st_code   = ST_EMPTY;
            phase_nxt = PH_HUNT;
          end else begin
            // keep the length for the readback
            rd_idx_nxt = '0;
            phase_nxt  = PH_DRAIN;
          end
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
    if (rd_issue) begin
      rd_idx_nxt = rd_idx_inc;
      if (rd_idx_inc == frame_len_r) begin
        frame_len_nxt = '0;
        phase_nxt     = PH_HUNT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HUNT;
      frame_len_r    <= '0;
      seen_r         <= '0;
      high_byte_r    <= '0;
      rd_idx_r       <= '0;
      rd_pend_r      <= 1'b0;
      out_valid_r    <= 1'b0;
      start_marker_r <= START_MARKER_RST;
      end_marker_r   <= END_MARKER_RST;
    end else begin
      phase_r     <= phase_nxt;
      frame_len_r <= frame_len_nxt;
      seen_r      <= seen_nxt;
      high_byte_r <= high_byte_nxt;
      rd_idx_r    <= rd_idx_nxt;
      if (rd_issue) begin
        rd_pend_r <= 1'b1;
      end else if (load_ram) begin
        rd_pend_r <= 1'b0;
      end
      if (load_ram || st_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_START_MARKER: start_marker_r <= cfg_data;
          CFG_END_MARKER:   end_marker_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Sample memory: written while parsing, read only while draining.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      sample_mem_r[seen_r[IDX_W-1:0]] <= {high_byte_r, in_rx_byte};
    end
    if (rd_issue) begin
      rd_data_r <= sample_mem_r[rd_idx_r[IDX_W-1:0]];
      rd_last_r <= (rd_idx_inc == frame_len_r);
    end
  end

  always_ff @(posedge clk) begin
    if (load_ram) begin
      out_value_r  <= rd_data_r;
      out_status_r <= ST_SAMPLE;
      out_last_r   <= rd_last_r;
    end else if (st_load) begin
      out_value_r  <= '0;
      out_status_r <= st_code;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sample_value  = out_value_r;
  assign out_frame_status  = out_status_r;
  assign out_last_of_frame = out_last_r;

  `SFD_ASSERT_ALWAYS(a_len_in_range, frame_len_r <= CNT_W'(MAX_SAMPLES), "frame length over capacity")
  `SFD_ASSERT_IMP(a_wr_in_frame, in_acc && (phase_r == PH_LOW), seen_r < frame_len_r, "sample write past frame length")
  `SFD_ASSERT_IMP(a_drain_idx, phase_r == PH_DRAIN, rd_idx_r < frame_len_r, "readback index past frame length")
  `SFD_ASSERT_IMP(a_last_ends_drain, rd_pend_r && rd_last_r, phase_r != PH_DRAIN, "read issued after last sample")

endmodule

// ----- bench/tb_sample_frame_deframer.sv -----
// ---------------------------------------------------------------------------
// Sample frame deframer testbench
// Streams received bytes into the deframer, predicts each status or sample
// request from a byte-level frame parser and compares every output request
// in order, over several marker settings, random stalls and a long hold-off.
// ---------------------------------------------------------------------------
module tb_sample_frame_deframer;
  import sfd_pkg::*;

  localparam int RUN_LIMIT   = 300000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;

  typedef struct packed {
    logic [15:0] value;
    status_t     status;
    logic        last;
  } deframed_t;

  // Byte-level frame parser plus the queue of requests it still awaits.
  class frame_checker;
    logic [7:0]  start_mark;
    logic [7:0]  end_mark;
    phase_t      parse_at;
    logic [6:0]  frame_len;
    logic [6:0]  seen;
    logic [7:0]  high_byte;
    logic [15:0] sample_buf [MAX_SAMPLES];
    deframed_t   pending_results [$];
    int          fail_count;

    function new();
      start_mark = START_MARKER_RST;
      end_mark   = END_MARKER_RST;
      parse_at   = PH_HUNT;
      frame_len  = '0;
      seen       = '0;
      high_byte  = '0;
      fail_count = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
      if (idx == CFG_START_MARKER) start_mark = data;
      else if (idx == CFG_END_MARKER) end_mark = data;
    endfunction

    function void push(logic [15:0] value, status_t status, logic last);
      deframed_t r;
      r.value  = value;
      r.status = status;
      r.last   = last;
      pending_results.push_back(r);
    endfunction

    function void take_byte(logic [7:0] b);
      int k;
      case (parse_at)
        PH_HUNT: begin
          if (b == start_mark) begin
            frame_len = '0;
            seen      = '0;
            parse_at  = PH_LEN;
          end
        end
        PH_LEN: begin
          seen = '0;
          if (int'(b) > MAX_SAMPLES) begin
            push(16'h0000, ST_TOO_LONG, 1'b1);
            frame_len = '0;
            parse_at  = PH_HUNT;
          end else begin
            frame_len = b[6:0];
            parse_at  = (b == 8'h00) ? PH_END : PH_HIGH;
          end
        end
        PH_HIGH: begin
          high_byte = b;
          parse_at  = PH_LOW;
        end
        PH_LOW: begin
          if (int'(seen) < MAX_SAMPLES) sample_buf[seen] = {high_byte, b};
          seen     = seen + 7'd1;
          parse_at = (seen >= frame_len) ? PH_END : PH_HIGH;
        end
        PH_END: begin
          if (b != end_mark) begin
            push(16'h0000, ST_BAD_END, 1'b1);
          end else if (frame_len == 0) begin
            push(16'h0000, ST_EMPTY, 1'b1);
          end else begin
            for (k = 0; k < int'(frame_len); k++)
              push(sample_buf[k], ST_SAMPLE, (k + 1 == int'(frame_len)));
          end
          frame_len = '0;
          seen      = '0;
          parse_at  = PH_HUNT;
        end
        default: parse_at = PH_HUNT;
      endcase
    endfunction

    task report(string msg);
      fail_count++;
      $display("ERROR at %0t: %s", $time, msg);
    endtask

    task match_result(logic [15:0] value, logic [1:0] status, logic last);
      deframed_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected request value %h status %0d last %0b",
                         value, status, last));
        return;
      end
      want = pending_results.pop_front();
      if (value !== want.value)
        report($sformatf("sample_value %h, want %h", value, want.value));
      if (status !== want.status)
        report($sformatf("frame_status %0d, want %0d", status, want.status));
      if (last !== want.last)
        report($sformatf("last_of_frame %0b, want %0b", last, want.last));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_rx_byte = 8'h00;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [15:0]          out_sample_value;
  logic [1:0]           out_frame_status;
  logic                 out_last_of_frame;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = 8'h00;

  frame_checker chk;
  bit           idle_on = 1'b1;
  bit           hold_req = 1'b0;
  int           hold_left = 0;
  int           stall_left = 0;
  int           bytes_sent = 0;
  int           cycles = 0;

  sample_frame_deframer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sample_value  (out_sample_value),
    .out_frame_status  (out_frame_status),
    .out_last_of_frame (out_last_of_frame),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= RUN_LIMIT) begin
      $display("sample_frame_deframer: mismatch");
      $finish;
    end
  end

  // Check the request taken at this edge, then pick the next ready level.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready)
      chk.match_result(out_sample_value, out_frame_status, out_last_of_frame);
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chk.take_byte(b);
    bytes_sent++;
  endtask

  // Favor the start marker in sample data so it shows up mid-frame.
  function automatic logic [7:0] sample_byte();
    if ($urandom_range(0, 7) == 0) return chk.start_mark;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_frame(input int len, input bit good_end);
    int i;
    send_byte(chk.start_mark);
    send_byte(8'(len));
    for (i = 0; i < len; i++) begin
      send_byte(sample_byte());
      send_byte(sample_byte());
    end
    send_byte(good_end ? chk.end_mark : chk.end_mark ^ 8'($urandom_range(1, 255)));
  endtask

  task automatic random_frames(input int n_bytes);
    int stop_at;
    int pick;
    int len;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 14) begin
        send_byte(chk.start_mark);
        send_byte(8'($urandom_range(MAX_SAMPLES + 1, 255)));
      end else begin
        if (pick < 16) len = $urandom_range(33, MAX_SAMPLES);
        else if (pick < 26) len = 0;
        else len = $urandom_range(1, 8);
        send_frame(len, $urandom_range(0, 99) < 85);
      end
    end
  endtask

  // Hold config changes until every request is out and the drain has settled.
  task automatic wait_drained();
    while (chk.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_markers(input logic [7:0] start_b, input logic [7:0] end_b,
                             input logic [CFG_IDX_W-1:0] spare_idx);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [7:0]           data [3];
    int                   i;
    idx[0] = CFG_START_MARKER;  data[0] = start_b;
    idx[1] = spare_idx;         data[1] = 8'($urandom_range(0, 255));
    idx[2] = CFG_END_MARKER;    data[2] = end_b;
    for (i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= data[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      chk.write_reg(idx[i], data[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] same_mark;
    chk = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset markers, noise, empty, bad end, oversized, extremes.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(0, 1'b1);
    send_frame(0, 1'b0);
    send_byte(chk.start_mark);
    send_byte(8'(MAX_SAMPLES + 1));
    send_byte(chk.start_mark);
    send_byte(8'd255);
    send_byte(chk.start_mark);
    send_byte(8'd1);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(chk.end_mark);
    // start marker as sample data, then a wrong end byte
    send_byte(chk.start_mark);
    send_byte(8'd2);
    send_byte(chk.start_mark);
    send_byte(chk.start_mark);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(~chk.end_mark);
    random_frames(75);
    in_valid <= 1'b0;
    wait_drained();

    set_markers(8'h00, 8'hFF, {CFG_IDX_W{1'b1}});
    hold_req = 1'b1;
    random_frames(75);
    in_valid <= 1'b0;
    wait_drained();

    set_markers(8'hFF, 8'h00, CFG_IDX_W'($urandom_range(CFG_END_MARKER + 1, 255)));
    send_frame(MAX_SAMPLES, 1'b1);
    random_frames(75);
    in_valid <= 1'b0;
    wait_drained();

    // same byte opens and closes a frame
    same_mark = 8'($urandom_range(0, 255));
    set_markers(same_mark, same_mark,
                CFG_IDX_W'($urandom_range(CFG_END_MARKER + 1, 255)));
    random_frames(75);
    in_valid <= 1'b0;
    wait_drained();

    set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                CFG_IDX_W'($urandom_range(CFG_END_MARKER + 1, 255)));
    idle_on = 1'b0;
    random_frames(60);
    in_valid <= 1'b0;

    wait_drained();
    repeat (2 * MAX_SAMPLES) @(posedge clk);
    if (chk.pending_results.size() != 0)
      chk.report($sformatf("%0d requests never arrived", chk.pending_results.size()));
    if (chk.fail_count == 0) begin
      $display("sample_frame_deframer: match");
    end else begin
      $display("sample_frame_deframer: mismatch");
    end
    $finish;
  end

endmodule
